// ----- src/signed_restoring_divider_top_macros.svh -----
// ----------------------------------------------------------------------------
// Signed restoring divider assertion macros
// Shared property shapes for the divider's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SIGNED_RESTORING_DIVIDER_TOP_MACROS_SVH
`define SIGNED_RESTORING_DIVIDER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SRD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define SRD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/srd_pkg.sv -----
// ----------------------------------------------------------------------------
// Signed restoring divider package
// Default width and the sign/exception flags carried down the pipeline.
// ----------------------------------------------------------------------------
package srd_pkg;

  // Default operand width
  localparam int DATA_WIDTH_DEF = 32;

  // Flags that ride along with each item
  typedef struct packed {
    logic neg_q;  // exactly one operand negative
    logic zdiv;   // divisor was zero
  } srd_flags_t;

endpackage

// ----- src/srd_if.sv -----
// ----------------------------------------------------------------------------
// Signed restoring divider channels
// Operand and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface srd_in_if #(
  parameter int W = srd_pkg::DATA_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] dividend_in;
  logic signed [W-1:0] divisor_in;

  modport source (output valid, output dividend_in, output divisor_in, input ready);
  modport sink   (input valid, input dividend_in, input divisor_in, output ready);
endinterface

interface srd_out_if #(
  parameter int W = srd_pkg::DATA_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] quotient_out;
  logic                overflow_flag;
  logic                zero_divisor_flag;

  modport source (output valid, output quotient_out, output overflow_flag,
                  output zero_divisor_flag, input ready);
  modport sink   (input valid, input quotient_out, input overflow_flag,
                  input zero_divisor_flag, output ready);
endinterface

// ----- src/srd_prep.sv -----
// ----------------------------------------------------------------------------
// Signed restoring divider operand stage
// Registers operand magnitudes, the result sign and the zero-divisor flag.
// ----------------------------------------------------------------------------
module srd_prep #(
  parameter int W = srd_pkg::DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_ready,
  input  logic [W-1:0]        dividend,
  input  logic [W-1:0]        divisor,
  output logic                dn_valid,
  input  logic                dn_ready,
  output logic [W-1:0]        dn_rem,
  output logic [W-1:0]        dn_aq,
  output logic [W-1:0]        dn_b,
  output srd_pkg::srd_flags_t dn_flags
);

  logic [W-1:0] a_mag;
  logic [W-1:0] b_mag;

  // Take absolute values; the most negative value maps to 2^(W-1)
  assign a_mag = dividend[W-1] ? (~dividend + {{(W-1){1'b0}}, 1'b1}) : dividend;
  assign b_mag = divisor[W-1]  ? (~divisor  + {{(W-1){1'b0}}, 1'b1}) : divisor;

  assign up_ready = !dn_valid || dn_ready;

  // Hold valid until the next stage takes the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  // Load payload on transfer
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_rem         <= '0;
      dn_aq          <= a_mag;
      dn_b           <= b_mag;
      dn_flags.neg_q <= dividend[W-1] ^ divisor[W-1];
      dn_flags.zdiv  <= (divisor == '0);
    end
  end

endmodule

// ----- src/srd_step.sv -----
// ----------------------------------------------------------------------------
// Signed restoring divider bit stage
// One restoring shift-and-subtract step: resolves one quotient bit.
// ----------------------------------------------------------------------------
`include "signed_restoring_divider_top_macros.svh"

module srd_step #(
  parameter int W = srd_pkg::DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_ready,
  input  logic [W-1:0]        up_rem,
  input  logic [W-1:0]        up_aq,
  input  logic [W-1:0]        up_b,
  input  srd_pkg::srd_flags_t up_flags,
  output logic                dn_valid,
  input  logic                dn_ready,
  output logic [W-1:0]        dn_rem,
  output logic [W-1:0]        dn_aq,
  output logic [W-1:0]        dn_b,
  output srd_pkg::srd_flags_t dn_flags
);

  logic [W-1:0] shifted;
  logic [W:0]   diff;
  logic         qbit;
  logic [W-1:0] rem_next;

  // Shift the next dividend bit into the partial remainder and trial-subtract
  assign shifted  = {up_rem[W-2:0], up_aq[W-1]};
  assign diff     = {1'b0, shifted} - {1'b0, up_b};
  assign qbit     = !diff[W];
  assign rem_next = qbit ? diff[W-1:0] : shifted;

  assign up_ready = !dn_valid || dn_ready;

  // Hold valid until the next stage takes the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  // Advance payload; quotient bits enter at the bottom of the dividend word
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_rem   <= rem_next;
      dn_aq    <= {up_aq[W-2:0], qbit};
      dn_b     <= up_b;
      dn_flags <= up_flags;
    end
  end

  // Partial remainder must stay below the divisor
  `SRD_ASSERT_IMP(a_rem_below_b, clk, rst, dn_valid && !dn_flags.zdiv,
    dn_rem < dn_b, "partial remainder not below divisor")
  // A stalled stage keeps its contents
  `SRD_ASSERT_NXT(a_stall_holds, clk, rst, dn_valid && !dn_ready,
    dn_valid && $stable(dn_aq) && $stable(dn_rem), "stalled stage lost data")
  // Zero divisor sets every quotient bit
  `SRD_ASSERT_IMP(a_zdiv_ones, clk, rst, up_valid && up_flags.zdiv,
    qbit, "zero divisor did not produce a one bit")

endmodule

// ----- src/srd_fix.sv -----
// ----------------------------------------------------------------------------
// Signed restoring divider result stage
// Applies sign, saturation and the zero-divisor override; output register.
// ----------------------------------------------------------------------------
module srd_fix #(
  parameter int W = srd_pkg::DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_ready,
  input  logic [W-1:0]        up_q,
  input  srd_pkg::srd_flags_t up_flags,
  srd_out_if.source           result
);

  logic [W-1:0] q_fixed;
  logic         ovf;

  // Pick final quotient: zero divisor, negate, saturate or pass
  always_comb begin
    ovf = 1'b0;
    priority if (up_flags.zdiv) begin
      q_fixed = '0;
    end else if (up_flags.neg_q) begin
      q_fixed = ~up_q + {{(W-1){1'b0}}, 1'b1};
    end else if (up_q[W-1]) begin
      q_fixed = {1'b0, {(W-1){1'b1}}};
      ovf     = 1'b1;
    end else begin
      q_fixed = up_q;
    end
  end

  assign up_ready = !result.valid || result.ready;

  // Hold the result until the sink takes the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (up_ready) begin
      result.valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      result.quotient_out      <= q_fixed;
      result.overflow_flag     <= ovf;
      result.zero_divisor_flag <= up_flags.zdiv;
    end
  end

endmodule

// ----- src/signed_restoring_divider_top.sv -----
// Stages: operand stage, one subtract-and-compare stage per quotient bit, result stage.
// Throughput: one operand pair per cycle while the output is not stalled.
// A stalled output backs up stage by stage; empty stages keep accepting.
// Reset (rst, synchronous, active high) clears all valid bits; no results are pending.
// ----------------------------------------------------------------------------
// Signed restoring divider top level
// Pipelined signed division truncating toward zero, with saturation and
// divide-by-zero flags.
// ----------------------------------------------------------------------------
`include "signed_restoring_divider_top_macros.svh"

module signed_restoring_divider_top #(
  parameter int DATA_WIDTH = srd_pkg::DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  srd_in_if.sink    operands,
  srd_out_if.source result
);

  localparam int W = DATA_WIDTH;

  logic                valid_s [0:W];
  logic                ready_s [0:W];
  logic [W-1:0]        rem_s   [0:W-1];
  logic [W-1:0]        aq_s    [0:W];
  logic [W-1:0]        b_s     [0:W];
  srd_pkg::srd_flags_t flags_s [0:W];

  // Operand magnitudes and flags
  srd_prep #(.W(W)) u_prep (
    .clk      (clk),
    .rst      (rst),
    .up_valid (operands.valid),
    .up_ready (operands.ready),
    .dividend (operands.dividend_in),
    .divisor  (operands.divisor_in),
    .dn_valid (valid_s[0]),
    .dn_ready (ready_s[0]),
    .dn_rem   (rem_s[0]),
    .dn_aq    (aq_s[0]),
    .dn_b     (b_s[0]),
    .dn_flags (flags_s[0])
  );

  // One stage per quotient bit, most significant first
  for (genvar k = 0; k < W; k++) begin : g_step
    if (k == W - 1) begin : g_last
      srd_step #(.W(W)) u_step (
        .clk      (clk),
        .rst      (rst),
        .up_valid (valid_s[k]),
        .up_ready (ready_s[k]),
        .up_rem   (rem_s[k]),
        .up_aq    (aq_s[k]),
        .up_b     (b_s[k]),
        .up_flags (flags_s[k]),
        .dn_valid (valid_s[k+1]),
        .dn_ready (ready_s[k+1]),
        .dn_rem   (),
        .dn_aq    (aq_s[k+1]),
        .dn_b     (b_s[k+1]),
        .dn_flags (flags_s[k+1])
      );
    end else begin : g_mid
      srd_step #(.W(W)) u_step (
        .clk      (clk),
        .rst      (rst),
        .up_valid (valid_s[k]),
        .up_ready (ready_s[k]),
        .up_rem   (rem_s[k]),
        .up_aq    (aq_s[k]),
        .up_b     (b_s[k]),
        .up_flags (flags_s[k]),
        .dn_valid (valid_s[k+1]),
        .dn_ready (ready_s[k+1]),
        .dn_rem   (rem_s[k+1]),
        .dn_aq    (aq_s[k+1]),
        .dn_b     (b_s[k+1]),
        .dn_flags (flags_s[k+1])
      );
    end
  end

  // Sign, saturation and output register
  srd_fix #(.W(W)) u_fix (
    .clk      (clk),
    .rst      (rst),
    .up_valid (valid_s[W]),
    .up_ready (ready_s[W]),
    .up_q     (aq_s[W]),
    .up_flags (flags_s[W]),
    .result   (result)
  );

  // Flags never both set
  `SRD_ASSERT_IMP(a_flags_excl, clk, rst, result.valid,
    !(result.overflow_flag && result.zero_divisor_flag), "both flags set")
  // Zero divisor gives a zero quotient
  `SRD_ASSERT_IMP(a_zdiv_zero, clk, rst, result.valid && result.zero_divisor_flag,
    result.quotient_out == '0, "zero divisor with nonzero quotient")
  // Overflow saturates to the largest positive value
  `SRD_ASSERT_IMP(a_ovf_sat, clk, rst, result.valid && result.overflow_flag,
    result.quotient_out == {1'b0, {(W-1){1'b1}}}, "overflow not saturated")

endmodule

// ----- verif/tb_signed_restoring_divider_top.sv -----
// ----------------------------------------------------------------------------
// Signed restoring divider testbench
// Streams operand pairs through the pipelined divider under random source
// gaps and sink stalls. Each transfer is checked against a behavioral
// restoring-division predictor, including the zero-divisor and saturation
// cases.
// ----------------------------------------------------------------------------
module tb_signed_restoring_divider_top;

  localparam int DW          = srd_pkg::DATA_WIDTH_DEF;
  localparam int NUM_RANDOM  = 1325;
  localparam int IDLE_LIMIT  = 4000;
  localparam int MAX_REPORTS = 10;

  localparam logic signed [DW-1:0] MOST_NEG = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] MOST_POS = {1'b0, {(DW-1){1'b1}}};

  typedef struct {
    logic signed [DW-1:0] dividend;
    logic signed [DW-1:0] divisor;
    int unsigned          gap;
  } operand_pair_t;

  typedef struct packed {
    logic signed [DW-1:0] quotient;
    logic                 overflow;
    logic                 zero_div;
  } quot_result_t;

  logic clk;
  logic rst;

  srd_in_if  #(.W(DW)) op_if ();
  srd_out_if #(.W(DW)) res_if ();

  signed_restoring_divider_top #(.DATA_WIDTH(DW)) dut (
    .clk      (clk),
    .rst      (rst),
    .operands (op_if),
    .result   (res_if)
  );

  operand_pair_t pend_q[$];
  quot_result_t  quot_expect_q[$];

  logic        op_fire;
  logic        res_fire;
  int unsigned gap_waited;
  int unsigned stall_left;
  int unsigned res_count;
  int unsigned idle_cycles;
  int unsigned error_cnt;

  // Clock: period 8
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Signed division truncating toward zero, by restoring shift-and-subtract
  function automatic quot_result_t divide_signed(logic signed [DW-1:0] dvd,
                                                 logic signed [DW-1:0] dvs);
    quot_result_t  res;
    logic          neg_a;
    logic          neg_b;
    logic [DW-1:0] mag_a;
    logic [DW-1:0] mag_b;
    logic [DW-1:0] q;
    logic [DW:0]   rem;
    neg_a = dvd[DW-1];
    neg_b = dvs[DW-1];
    mag_a = neg_a ? (~dvd) + 1'b1 : dvd;
    mag_b = neg_b ? (~dvs) + 1'b1 : dvs;
    res   = '0;
    if (mag_b == '0) begin
      res.zero_div = 1'b1;
      return res;
    end
    rem = '0;
    q   = '0;
    for (int i = DW - 1; i >= 0; i--) begin
      rem = {rem[DW-1:0], mag_a[i]};
      if (rem >= {1'b0, mag_b}) begin
        rem  = rem - {1'b0, mag_b};
        q[i] = 1'b1;
      end
    end
    if (neg_a != neg_b) begin
      res.quotient = (~q) + 1'b1;
    end else if (q[DW-1]) begin
      // most negative over minus one: clamp to largest positive
      res.quotient = MOST_POS;
      res.overflow = 1'b1;
    end else begin
      res.quotient = q;
    end
    return res;
  endfunction

  // Random operand, spread over full range, small values, scaled values and edges
  function automatic logic signed [DW-1:0] rand_operand();
    logic signed [DW-1:0] v;
    v = $urandom();
    case ($urandom_range(0, 7))
      0, 1, 2: ;
      3: v = $signed($urandom_range(0, 40)) - 20;
      4: v = v >>> $urandom_range(0, DW - 1);
      5: v = $urandom() >> $urandom_range(0, DW - 1);
      6: begin
        case ($urandom_range(0, 4))
          0: v = MOST_NEG;
          1: v = MOST_POS;
          2: v = -1;
          3: v = 1;
          default: v = 0;
        endcase
      end
      default: v = v & ~(32'hFFFF_FFFF << $urandom_range(1, DW));
    endcase
    return v;
  endfunction

  function automatic operand_pair_t make_pair(logic signed [DW-1:0] dvd,
                                              logic signed [DW-1:0] dvs,
                                              bit no_gap);
    operand_pair_t p;
    p.dividend = dvd;
    p.divisor  = dvs;
    p.gap      = no_gap ? 0 : $urandom_range(0, 7);
    return p;
  endfunction

  // Driver: present operand pairs at the falling edge, holding each until transfer
  always @(negedge clk) begin : drive_operands
    operand_pair_t nxt;
    if (rst) begin
      op_if.valid <= 1'b0;
      gap_waited  <= 0;
    end else if (!(op_if.valid && !op_fire)) begin
      if (pend_q.size() == 0) begin
        op_if.valid <= 1'b0;
      end else if (gap_waited < pend_q[0].gap) begin
        op_if.valid <= 1'b0;
        gap_waited  <= gap_waited + 1;
      end else begin
        nxt = pend_q.pop_front();
        op_if.valid       <= 1'b1;
        op_if.dividend_in <= nxt.dividend;
        op_if.divisor_in  <= nxt.divisor;
        gap_waited        <= 0;
      end
    end
  end

  // Sink: draw a stall per result, with stretches of none
  always @(negedge clk) begin : drive_ready
    int unsigned n;
    if (rst) begin
      res_if.ready <= 1'b0;
      stall_left   <= 0;
    end else if (res_fire) begin
      n = ((res_count % 128) < 24) ? 0 : $urandom_range(0, 7);
      stall_left   <= n;
      res_if.ready <= (n == 0);
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      res_if.ready <= (stall_left == 1);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // Monitor: record operand transfers, check result transfers, watch for a hang
  always @(posedge clk) begin : monitor
    quot_result_t exp_res;
    if (rst) begin
      op_fire     <= 1'b0;
      res_fire    <= 1'b0;
      res_count   <= 0;
      idle_cycles <= 0;
    end else begin
      op_fire  <= op_if.valid && op_if.ready;
      res_fire <= res_if.valid && res_if.ready;

      if (op_if.valid && op_if.ready) begin
        quot_expect_q.push_back(divide_signed(op_if.dividend_in, op_if.divisor_in));
      end

      if (res_if.valid && res_if.ready) begin
        res_count <= res_count + 1;
        if (quot_expect_q.size() == 0) begin
          error_cnt = error_cnt + 1;
          if (error_cnt <= MAX_REPORTS) begin
            $display("ERROR: unexpected result q=%0d ovf=%0b zdiv=%0b",
                     res_if.quotient_out, res_if.overflow_flag,
                     res_if.zero_divisor_flag);
          end
        end else begin
          exp_res = quot_expect_q.pop_front();
          if (res_if.quotient_out !== exp_res.quotient ||
              res_if.overflow_flag !== exp_res.overflow ||
              res_if.zero_divisor_flag !== exp_res.zero_div) begin
            error_cnt = error_cnt + 1;
            if (error_cnt <= MAX_REPORTS) begin
              $display("ERROR: result %0d: exp q=%0d ovf=%0b zdiv=%0b, got q=%0d ovf=%0b zdiv=%0b",
                       res_count, exp_res.quotient, exp_res.overflow, exp_res.zero_div,
                       res_if.quotient_out, res_if.overflow_flag,
                       res_if.zero_divisor_flag);
            end
          end
        end
      end

      // Abort when nothing moves for too long
      if ((op_if.valid && op_if.ready) || (res_if.valid && res_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    error_cnt         = 0;
    rst               = 1'b1;
    op_if.valid       = 1'b0;
    op_if.dividend_in = '0;
    op_if.divisor_in  = '0;
    res_if.ready      = 1'b0;

    // Directed: field extremes, sign combinations, zero divisor, saturation
    pend_q.push_back(make_pair(0, 1, 0));
    pend_q.push_back(make_pair(1, 1, 0));
    pend_q.push_back(make_pair(-1, 1, 0));
    pend_q.push_back(make_pair(MOST_POS, 1, 0));
    pend_q.push_back(make_pair(MOST_NEG, 1, 0));
    pend_q.push_back(make_pair(MOST_NEG, -1, 0));
    pend_q.push_back(make_pair(MOST_NEG, MOST_NEG, 1));
    pend_q.push_back(make_pair(MOST_POS, MOST_POS, 1));
    pend_q.push_back(make_pair(MOST_POS, MOST_NEG, 1));
    pend_q.push_back(make_pair(MOST_NEG, MOST_POS, 0));
    pend_q.push_back(make_pair(MOST_POS, -1, 0));
    pend_q.push_back(make_pair(0, 0, 0));
    pend_q.push_back(make_pair(5, 0, 1));
    pend_q.push_back(make_pair(-5, 0, 1));
    pend_q.push_back(make_pair(MOST_NEG, 0, 0));
    pend_q.push_back(make_pair(MOST_POS, 0, 0));
    pend_q.push_back(make_pair(7, 2, 1));
    pend_q.push_back(make_pair(-7, 2, 1));
    pend_q.push_back(make_pair(7, -2, 1));
    pend_q.push_back(make_pair(-7, -2, 1));
    pend_q.push_back(make_pair(1, -1, 0));
    pend_q.push_back(make_pair(-1, -1, 0));
    pend_q.push_back(make_pair(0, -1, 0));
    pend_q.push_back(make_pair(5, 7, 0));
    pend_q.push_back(make_pair(-1, MOST_NEG, 0));

    // Random: mixed operand shapes, with bursts of back-to-back pairs
    for (int i = 0; i < NUM_RANDOM; i++) begin
      pend_q.push_back(make_pair(rand_operand(), rand_operand(), (i % 100) < 20));
    end

    // Hold reset, then release it at a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for every pair to transfer, then for every result
    while (pend_q.size() != 0 || op_if.valid) @(posedge clk);
    while (quot_expect_q.size() != 0) @(posedge clk);
    repeat (DW + 16) @(posedge clk);

    if (error_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/srd_pkg.sv
src/srd_if.sv
src/srd_prep.sv
src/srd_step.sv
src/srd_fix.sv
src/signed_restoring_divider_top.sv
verif/tb_signed_restoring_divider_top.sv
